>>> src/nnts_pkg.sv
// ----------------------------------------------------------------------------
// nnts_pkg
// Shared constants, types and helpers for the nearest-neighbour search block.
// ----------------------------------------------------------------------------
package nnts_pkg;

  localparam int MAX_RECORDS = 4096;
  localparam int MAX_RESULTS = 10;
  localparam int DIMS        = 6;
  localparam int NUM_EXP     = 3;
  localparam int IDX_W       = 12;
  localparam int CNT_W       = 13;
  localparam int DIST_W      = 19;
  localparam int VAL_W       = 16;
  localparam int ROW_W       = DIMS * VAL_W;
  localparam int SQ_W        = 35;   // sum of six 17-bit squares
  localparam int ROOT_W      = 18;
  localparam int RANK_W      = 4;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_QUERY = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_BAD  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef logic [ROW_W-1:0] row_t;

  // One scored candidate (index and summed lane distances) travelling to the merge stage
  typedef struct packed {
    logic              vld;
    logic [IDX_W-1:0]  idx;
    logic [DIST_W-1:0] score;
  } cand_t;

endpackage

>>> src/nearest_neighbour_topk_search_top.sv
// ----------------------------------------------------------------------------
// nearest_neighbour_topk_search_top
// Record table with k-nearest-neighbour search.
// ----------------------------------------------------------------------------
// Use: load records with cmd 0 requests, one experiment (six Q8.8 values)
// per request; experiment 2 commits the record. A cmd 1 request scores
// every other stored record against query_index and returns the nearest
// ones, one result per output request, tlast on the final one. cmd 2
// clears the table. result_limit is to be written on the cfg channel only
// while idle; the block does not enforce this. Loads may follow back to
// back. A query scans one record per cycle from the table memory through
// three distance lanes of 20 pipeline stages into the merge; results then
// follow one per cycle while the receiver is ready. A full-table load or a
// bad query answers via S_ONE and the output register. Reset clears the
// record count and pending mask and sets the limit to 10; the table
// contents need no clearing pass. A stalled receiver holds the output
// register; no new request is taken until all results are delivered.
// ----------------------------------------------------------------------------
module nearest_neighbour_topk_search_top
  import nnts_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // tdata: experiment[1:0], value_0..value_5[97:2], query_index[109:98]
  input  logic [111:0] in_tdata,
  // tuser: cmd
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // tdata: rank[3:0], neighbour[15:4], distance[34:16], status[36:35]
  output logic [39:0]  out_tdata,
  output logic         out_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [3:0]   cfg_data
);

  localparam int LAT = 3 + ROOT_W;  // read, square, sum and root stages

  typedef enum logic [2:0] {S_IDLE, S_QRD, S_SCAN, S_OUT, S_ONE} state_t;

  state_t             state_r;
  logic [RANK_W-1:0]  limit_r;
  logic [CNT_W-1:0]   count_r;
  logic [NUM_EXP-1:0] pmask_r;
  row_t               pend_r [NUM_EXP];
  row_t               mem [NUM_EXP][MAX_RECORDS];
  row_t               rd_r [NUM_EXP];
  row_t               q_r  [NUM_EXP];
  logic [IDX_W-1:0]   qidx_r;
  logic [CNT_W-1:0]   scan_r;
  logic [CNT_W-1:0]   rcv_r;
  logic [LAT-1:0]     vpipe_r;
  logic [IDX_W-1:0]   ipipe_r [LAT];
  logic [RANK_W-1:0]  oidx_r;
  logic [1:0]         st_r;
  logic               ovld_r;
  logic [39:0]        odata_r;
  logic               olast_r;
  logic               mclr;

  // Input field unpacking
  logic [1:0]       f_exp;
  logic [IDX_W-1:0] f_q;
  row_t             f_row;
  assign f_exp = in_tdata[1:0];
  assign f_row = in_tdata[97:2];
  assign f_q   = in_tdata[109:98];

  assign in_tready = (state_r == S_IDLE) && !ovld_r;
  assign cfg_ready = 1'b1;

  // Table memory: one write port, one registered read port per experiment
  logic              mem_we;
  logic [IDX_W-1:0]  mem_ra;
  always_ff @(posedge clk) begin
    for (int x = 0; x < NUM_EXP; x++) begin
      if (mem_we)
        mem[x][count_r[IDX_W-1:0]] <= (x == NUM_EXP-1) ? f_row :
                                      (pmask_r[x] ? pend_r[x] : '0);
      rd_r[x] <= mem[x][mem_ra];
    end
  end

  logic acc_in;
  assign acc_in = in_tvalid && in_tready;
  assign mem_we = acc_in && in_tuser == CMD_LOAD && count_r != CNT_W'(MAX_RECORDS)
                  && f_exp == 2'd2;
  assign mem_ra = (state_r == S_IDLE) ? f_q : scan_r[IDX_W-1:0];

  // Lanes, one per experiment
  logic [ROOT_W-1:0] root [NUM_EXP];
  for (genvar x = 0; x < NUM_EXP; x++) begin : g_lane
    nnts_lane u_lane (.clk(clk), .a_row(q_r[x]), .b_row(rd_r[x]), .root(root[x]));
  end

  cand_t             cand;
  logic [RANK_W-1:0] eff_lim, kept;
  logic [IDX_W-1:0]  bi;
  logic [DIST_W-1:0] bd;
  assign eff_lim = (limit_r == '0) ? RANK_W'(1) :
                   (limit_r > RANK_W'(MAX_RESULTS)) ? RANK_W'(MAX_RESULTS) : limit_r;
  assign cand.vld   = vpipe_r[LAT-1];
  assign cand.idx   = ipipe_r[LAT-1];
  assign cand.score = DIST_W'(root[0]) + DIST_W'(root[1]) + DIST_W'(root[2]);
  assign mclr       = (state_r == S_QRD);

  nnts_merge u_merge (.clk(clk), .clr(mclr), .limit(eff_lim), .cand(cand),
                      .rd_sel(oidx_r), .rd_idx(bi), .rd_dist(bd), .kept(kept));

  // Candidate index/valid delay line matching the lanes
  always_ff @(posedge clk) begin
    if (!rst_n) vpipe_r <= '0;
    else vpipe_r <= {vpipe_r[LAT-2:0],
                     (state_r == S_SCAN) && scan_r < count_r && scan_r[IDX_W-1:0] != qidx_r
                     && scan_r <= count_r};
    ipipe_r[0] <= scan_r[IDX_W-1:0];
    for (int i = 1; i < LAT; i++) ipipe_r[i] <= ipipe_r[i-1];
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      limit_r <= RANK_W'(MAX_RESULTS);
      count_r <= '0;
      pmask_r <= '0;
      ovld_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) limit_r <= cfg_data;
      // Output register: take a new result or release the delivered one
      if ((state_r == S_OUT || state_r == S_ONE) && (!ovld_r || out_tready))
        ovld_r <= 1'b1;
      else if (out_tready)
        ovld_r <= 1'b0;
      case (state_r)
        S_IDLE: if (acc_in) begin
          case (in_tuser)
            CMD_LOAD: begin
              if (count_r == CNT_W'(MAX_RECORDS)) begin
                st_r <= ST_FULL; state_r <= S_ONE;
              end else if (f_exp != 2'd3) begin
                if (f_exp == 2'd2) begin
                  count_r <= count_r + 1'b1; pmask_r <= '0;
                end else begin
                  pend_r[f_exp] <= f_row; pmask_r[f_exp] <= 1'b1;
                end
              end
            end
            CMD_QUERY: begin
              qidx_r <= f_q;
              if (CNT_W'(f_q) >= count_r || count_r < CNT_W'(2)) begin
                st_r <= ST_BAD; state_r <= S_ONE;
              end else state_r <= S_QRD;
            end
            CMD_CLEAR: begin count_r <= '0; pmask_r <= '0; end
            default: ;
          endcase
        end
        S_QRD: begin
          for (int x = 0; x < NUM_EXP; x++) q_r[x] <= rd_r[x];
          scan_r <= '0; rcv_r <= '0; state_r <= S_SCAN;
        end
        S_SCAN: begin
          if (scan_r <= count_r) scan_r <= scan_r + 1'b1;
          rcv_r <= rcv_r + 1'b1;
          if (rcv_r == count_r + CNT_W'(LAT + 1)) begin
            oidx_r <= '0; state_r <= S_OUT;
          end
        end
        S_OUT: if (!ovld_r || out_tready) begin
          odata_r <= {3'b0, ST_OK, bd, bi, oidx_r};
          olast_r <= (oidx_r + 1'b1 == kept);
          oidx_r  <= oidx_r + 1'b1;
          if (oidx_r + 1'b1 == kept) state_r <= S_IDLE;
        end
        S_ONE: if (!ovld_r || out_tready) begin
          odata_r <= {3'b0, st_r, 35'b0};
          olast_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = ovld_r;
  assign out_tdata  = odata_r;
  assign out_tlast  = olast_r;

endmodule

>>> src/nnts_lane.sv
// ----------------------------------------------------------------------------
// nnts_lane
// Distance lane for one experiment: squared Euclidean distance then a
// pipelined integer square root, one new pair accepted every cycle.
// ----------------------------------------------------------------------------
module nnts_lane
  import nnts_pkg::*;
(
  input  logic              clk,
  input  row_t              a_row,
  input  row_t              b_row,
  output logic [ROOT_W-1:0] root
);

  localparam int STAGES = ROOT_W;
  localparam int RW     = SQ_W + 1;

  logic [2*VAL_W+1:0] sq_r [DIMS];
  logic [SQ_W-1:0]    acc_r;
  logic [RW-1:0]      rem_r  [STAGES+1];
  logic [ROOT_W-1:0]  res_r  [STAGES+1];

  // Stage 1: per-dimension squares
  always_ff @(posedge clk) begin
    for (int d = 0; d < DIMS; d++) begin
      logic signed [VAL_W:0]       df;
      logic signed [2*VAL_W+1:0]   sq;
      df = $signed({a_row[d*VAL_W+VAL_W-1], a_row[d*VAL_W +: VAL_W]})
         - $signed({b_row[d*VAL_W+VAL_W-1], b_row[d*VAL_W +: VAL_W]});
      sq = df * df;
      sq_r[d] <= sq;
    end
  end

  // Stage 2: sum of squares
  always_ff @(posedge clk) begin
    logic [SQ_W-1:0] s;
    s = '0;
    for (int d = 0; d < DIMS; d++) s = s + SQ_W'(sq_r[d]);
    acc_r <= s;
  end

  assign rem_r[0] = RW'(acc_r);
  assign res_r[0] = '0;

  // Restoring square root, one result bit per stage
  for (genvar g = 0; g < STAGES; g++) begin : g_sqrt
    localparam int B = STAGES - 1 - g;
    always_ff @(posedge clk) begin
      logic [RW-1:0] trial;
      trial = (RW'(res_r[g]) << (B + 1)) | (RW'(1) << (2 * B));
      if (rem_r[g] >= trial) begin
        rem_r[g+1] <= rem_r[g] - trial;
        res_r[g+1] <= res_r[g] | (ROOT_W'(1) << B);
      end else begin
        rem_r[g+1] <= rem_r[g];
        res_r[g+1] <= res_r[g];
      end
    end
  end

  assign root = res_r[STAGES];

endmodule

>>> src/nnts_merge.sv
// ----------------------------------------------------------------------------
// nnts_merge
// Sorted best-list: inserts one candidate per cycle, keeps up to limit
// entries in ascending distance, earlier candidate wins ties.
// ----------------------------------------------------------------------------
module nnts_merge
  import nnts_pkg::*;
(
  input  logic                     clk,
  input  logic                     clr,
  input  logic [RANK_W-1:0]        limit,
  input  cand_t                    cand,
  input  logic [RANK_W-1:0]        rd_sel,
  output logic [IDX_W-1:0]         rd_idx,
  output logic [DIST_W-1:0]        rd_dist,
  output logic [RANK_W-1:0]        kept
);

  logic [IDX_W-1:0]  idx_r  [MAX_RESULTS];
  logic [DIST_W-1:0] dist_r [MAX_RESULTS];
  logic [RANK_W-1:0] kept_r;

  // Shift-register insertion across all slots
  always_ff @(posedge clk) begin
    if (clr) begin
      kept_r <= '0;
    end else if (cand.vld) begin
      for (int p = 0; p < MAX_RESULTS; p++) begin
        logic here_ok, prev_ok;
        here_ok = (RANK_W'(p) < kept_r) && (dist_r[p] > cand.score);
        prev_ok = (p > 0) && (RANK_W'(p-1) < kept_r) && (dist_r[(p>0)?p-1:0] > cand.score);
        if (RANK_W'(p) < limit) begin
          if (prev_ok) begin
            idx_r[p]  <= idx_r[(p>0)?p-1:0];
            dist_r[p] <= dist_r[(p>0)?p-1:0];
          end else if (here_ok || RANK_W'(p) == kept_r) begin
            idx_r[p]  <= cand.idx;
            dist_r[p] <= cand.score;
          end
        end
      end
      if (kept_r < limit) kept_r <= kept_r + 1'b1;
    end
  end

  assign rd_idx  = idx_r[rd_sel];
  assign rd_dist = dist_r[rd_sel];
  assign kept    = kept_r;

endmodule

>>> src/nnts_checker.sv
// ----------------------------------------------------------------------------
// nnts_checker
// Port-level checks for the nearest-neighbour search block.
// ----------------------------------------------------------------------------
module nnts_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        out_tlast
);

  // Stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  // No new request while a result waits
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("request taken while result pending");

  // Error results (always single) must carry tlast
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[36:35] != 2'd0 |-> out_tlast)
    else $error("error result not last");

  // Rank never exceeds nine
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[3:0] <= 4'd9) else $error("rank out of range");

endmodule

bind nearest_neighbour_topk_search_top nnts_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tlast(out_tlast));
